// File: sv/ovca_pkg.sv
// ----------------------------------------------------------------------------
// ovca_pkg
// Shared types and constants of the output VC credit allocator: request and
// error codes, the per-VC entry layout and the control states.
// ----------------------------------------------------------------------------
package ovca_pkg;

  // Fixed field widths of the request and result transfers.
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned VNET_W   = 2;
  localparam int unsigned VC_W     = 4;
  localparam int unsigned CREDIT_W = 5;
  localparam int unsigned ERR_W    = 2;

  // Downstream buffer depth per VC: largest, smallest and reset value.
  localparam logic [CREDIT_W-1:0] DEPTH_MAX   = CREDIT_W'(16);
  localparam logic [CREDIT_W-1:0] DEPTH_MIN   = CREDIT_W'(1);
  localparam logic [CREDIT_W-1:0] DEPTH_RESET = CREDIT_W'(4);

  // Request codes; the remaining codes behave as a query.
  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC_VNET = 3'd0,
    REQ_ALLOC_VC   = 3'd1,
    REQ_FLIT_SENT  = 3'd2,
    REQ_CREDIT_RET = 3'd3,
    REQ_QUERY      = 3'd4
  } req_type_t;

  // Result error codes.
  typedef enum logic [ERR_W-1:0] {
    ERR_OK        = 2'd0,
    ERR_UNDERFLOW = 2'd1,
    ERR_OVERFLOW  = 2'd2
  } err_code_t;

  // State of one downstream VC as it is kept in the row memory.
  typedef struct packed {
    logic                active;
    logic [CREDIT_W-1:0] credits;
  } vc_entry_t;

  localparam int unsigned ENT_W = $bits(vc_entry_t);

  // Control sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctl_state_t;

endpackage

// File: sv/ovca_ram.sv
// ----------------------------------------------------------------------------
// ovca_ram
// Generic synchronous RAM: one write port and two read ports, both reads
// registered and held while the shared read enable is low.
// ----------------------------------------------------------------------------
module ovca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                         rdata_a,
  output logic [WIDTH-1:0]                         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: sv/output_vc_credit_allocator.sv
// ----------------------------------------------------------------------------
// output_vc_credit_allocator
// Output-port VC allocation and credit tracking for a network-on-chip router.
// ----------------------------------------------------------------------------
// Each request passes through the transfer, which reads the vnet's row and
// the VC's row of the VC state memory into the read registers, and the
// execute state, which computes the result, writes the changed row back and
// loads the output register. A new request is taken once the previous one has
// reached the output register, so only one request is in flight; a full output
// register holds the execute state until emptied. The memory holds one row per
// virtual network (idle/active bit and credit count for each of its VCs).
// Per-row valid bits stand in for clearing: after reset every VC is idle, and
// after reset or a credits_per_vc write every counter reads as the configured
// depth, with no clearing pass. credits_per_vc is clamped to 1..16.
// ----------------------------------------------------------------------------
module output_vc_credit_allocator #(
  parameter int unsigned NUM_VNETS    = 4,
  parameter int unsigned VCS_PER_VNET = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration.
  input  logic                               credits_per_vc_we,
  input  logic [ovca_pkg::CREDIT_W-1:0]      credits_per_vc,
  // Request channel.
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ovca_pkg::REQ_W-1:0]         req_type,
  input  logic [ovca_pkg::VNET_W-1:0]        vnet,
  input  logic [ovca_pkg::VC_W-1:0]          vc,
  input  logic                               free_signal,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               granted,
  output logic [ovca_pkg::VC_W-1:0]          granted_vc,
  output logic                               vnet_has_idle,
  output logic                               vc_idle,
  output logic                               vc_has_credit,
  output logic [ovca_pkg::CREDIT_W-1:0]      vc_credits,
  output logic [ovca_pkg::ERR_W-1:0]         error_code
);

  localparam int unsigned NUM_VCS = NUM_VNETS * VCS_PER_VNET;
  localparam int unsigned ROW_W   = NUM_VNETS > 1 ? $clog2(NUM_VNETS) : 1;
  localparam int unsigned COL_W   = VCS_PER_VNET > 1 ? $clog2(VCS_PER_VNET) : 1;
  localparam int unsigned LINE_W  = VCS_PER_VNET * ovca_pkg::ENT_W;
  localparam int unsigned NUM_CODES = 2 ** ovca_pkg::VC_W;

  // Constant tables: row and column of each VC number.
  logic [ROW_W-1:0] vc_row_lut [NUM_CODES];
  logic [COL_W-1:0] vc_col_lut [NUM_CODES];

  for (genvar i = 0; i < NUM_CODES; i++) begin : g_lut
    assign vc_row_lut[i] = ROW_W'(i < NUM_VCS ? i / VCS_PER_VNET : 0);
    assign vc_col_lut[i] = COL_W'(i < NUM_VCS ? i % VCS_PER_VNET : 0);
  end

  // Control.
  ovca_pkg::ctl_state_t state, state_next;
  logic in_fire, exec_fire;

  // Latched request.
  logic [ovca_pkg::REQ_W-1:0]  req_q;
  logic [ovca_pkg::VNET_W-1:0] vnet_q;
  logic [ovca_pkg::VC_W-1:0]   vc_q;
  logic                        free_q;
  logic [ROW_W-1:0]            vnet_row_q;
  logic [ROW_W-1:0]            vc_row_q;
  logic [COL_W-1:0]            vc_col_q;

  // Configuration and row valid bits.
  logic [ovca_pkg::CREDIT_W-1:0] depth;
  logic [NUM_VNETS-1:0]          act_vld;
  logic [NUM_VNETS-1:0]          cr_vld;

  // Memory ports.
  logic              mem_we;
  logic [ROW_W-1:0]  mem_waddr;
  logic [LINE_W-1:0] mem_wdata;
  logic [ROW_W-1:0]  rd_vnet_row;
  logic [LINE_W-1:0] rdata_vnet;
  logic [LINE_W-1:0] rdata_vc;

  // Execute-stage values.
  ovca_pkg::vc_entry_t       row_a [VCS_PER_VNET];
  ovca_pkg::vc_entry_t       row_b [VCS_PER_VNET];
  ovca_pkg::vc_entry_t       row_w [VCS_PER_VNET];
  logic                      vnet_ok, vc_ok, in_vnet_ok;
  logic                      has_idle;
  logic [COL_W-1:0]          first_idle;
  ovca_pkg::vc_entry_t       cur;
  logic [ovca_pkg::CREDIT_W-1:0] cr_new;
  logic                      res_granted;
  logic [ovca_pkg::VC_W-1:0] res_gvc;
  ovca_pkg::err_code_t       res_err;
  logic                      wr_vnet_row;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ovca_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ovca_pkg::ST_IDLE: if (in_valid) state_next = ovca_pkg::ST_EXEC;
      ovca_pkg::ST_EXEC: if (!out_valid || out_ready) state_next = ovca_pkg::ST_IDLE;
      default:           state_next = ovca_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = 1'b0;
    exec_fire = 1'b0;
    unique case (state)
      ovca_pkg::ST_IDLE: in_ready  = 1'b1;
      ovca_pkg::ST_EXEC: exec_fire = !out_valid || out_ready;
      default:           in_ready  = 1'b0;
    endcase
  end

  assign in_fire = in_valid && in_ready;

  // Read addresses come straight from the request ports.
  assign in_vnet_ok  = 32'(vnet) < NUM_VNETS;
  assign rd_vnet_row = in_vnet_ok ? ROW_W'(vnet) : '0;

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_q      <= req_type;
      vnet_q     <= vnet;
      vc_q       <= vc;
      free_q     <= free_signal;
      vnet_row_q <= rd_vnet_row;
      vc_row_q   <= vc_row_lut[vc];
      vc_col_q   <= vc_col_lut[vc];
    end
  end

  // Depth register; a write reloads every counter through the valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= ovca_pkg::DEPTH_RESET;
    end else if (credits_per_vc_we) begin
      if (credits_per_vc < ovca_pkg::DEPTH_MIN) begin
        depth <= ovca_pkg::DEPTH_MIN;
      end else if (credits_per_vc > ovca_pkg::DEPTH_MAX) begin
        depth <= ovca_pkg::DEPTH_MAX;
      end else begin
        depth <= credits_per_vc;
      end
    end
  end

  // Row valid bits: active bits survive a depth write, credits do not.
  always_ff @(posedge clk) begin
    if (rst) begin
      act_vld <= '0;
      cr_vld  <= '0;
    end else begin
      if (mem_we) begin
        act_vld[mem_waddr] <= 1'b1;
      end
      if (credits_per_vc_we) begin
        cr_vld <= '0;
      end else if (mem_we) begin
        cr_vld[mem_waddr] <= 1'b1;
      end
    end
  end

  // VC state memory, one row per virtual network.
  ovca_ram #(
    .WIDTH (LINE_W),
    .DEPTH (NUM_VNETS)
  ) u_row_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (in_fire),
    .raddr_a (rd_vnet_row),
    .raddr_b (vc_row_lut[vc]),
    .rdata_a (rdata_vnet),
    .rdata_b (rdata_vc)
  );

  // Merge read rows with their valid bits.
  always_comb begin
    for (int k = 0; k < VCS_PER_VNET; k++) begin
      row_a[k] = ovca_pkg::vc_entry_t'(rdata_vnet[k*ovca_pkg::ENT_W +: ovca_pkg::ENT_W]);
      row_b[k] = ovca_pkg::vc_entry_t'(rdata_vc[k*ovca_pkg::ENT_W +: ovca_pkg::ENT_W]);
      if (!act_vld[vnet_row_q]) row_a[k].active  = 1'b0;
      if (!cr_vld[vnet_row_q])  row_a[k].credits = depth;
      if (!act_vld[vc_row_q])   row_b[k].active  = 1'b0;
      if (!cr_vld[vc_row_q])    row_b[k].credits = depth;
    end
  end

  // Lowest idle VC of the requested vnet.
  always_comb begin
    has_idle   = 1'b0;
    first_idle = '0;
    for (int k = VCS_PER_VNET - 1; k >= 0; k--) begin
      if (!row_a[k].active) begin
        has_idle   = 1'b1;
        first_idle = COL_W'(k);
      end
    end
  end

  assign vnet_ok = 32'(vnet_q) < NUM_VNETS;
  assign vc_ok   = 32'(vc_q) < NUM_VCS;
  assign cur     = row_b[vc_col_q];

  // Request execution: grant, credit update and the row to write back.
  always_comb begin
    row_w       = row_b;
    cr_new      = cur.credits;
    res_granted = 1'b0;
    res_gvc     = '0;
    res_err     = ovca_pkg::ERR_OK;
    wr_vnet_row = 1'b0;
    mem_we      = 1'b0;
    unique case (ovca_pkg::req_type_t'(req_q))
      ovca_pkg::REQ_ALLOC_VNET: begin
        row_w       = row_a;
        wr_vnet_row = 1'b1;
        if (vnet_ok && has_idle) begin
          row_w[first_idle].active = 1'b1;
          res_granted = 1'b1;
          res_gvc     = ovca_pkg::VC_W'(32'(vnet_q) * VCS_PER_VNET + 32'(first_idle));
          mem_we      = exec_fire;
        end
      end
      ovca_pkg::REQ_ALLOC_VC: begin
        if (vc_ok && !cur.active) begin
          row_w[vc_col_q].active = 1'b1;
          res_granted = 1'b1;
          res_gvc     = vc_q;
          mem_we      = exec_fire;
        end
      end
      ovca_pkg::REQ_FLIT_SENT: begin
        if (vc_ok) begin
          if (cur.credits == '0) begin
            res_err = ovca_pkg::ERR_UNDERFLOW;
          end else begin
            cr_new = cur.credits - ovca_pkg::CREDIT_W'(1);
          end
          row_w[vc_col_q].credits = cr_new;
          mem_we = exec_fire;
        end
      end
      ovca_pkg::REQ_CREDIT_RET: begin
        if (vc_ok) begin
          if (cur.credits >= depth) begin
            res_err = ovca_pkg::ERR_OVERFLOW;
          end else begin
            cr_new = cur.credits + ovca_pkg::CREDIT_W'(1);
          end
          row_w[vc_col_q].credits = cr_new;
          if (free_q) row_w[vc_col_q].active = 1'b0;
          mem_we = exec_fire;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Write-back row.
  assign mem_waddr = wr_vnet_row ? vnet_row_q : vc_row_q;

  always_comb begin
    for (int k = 0; k < VCS_PER_VNET; k++) begin
      mem_wdata[k*ovca_pkg::ENT_W +: ovca_pkg::ENT_W] = row_w[k];
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload; query flags are taken before the update.
  always_ff @(posedge clk) begin
    if (exec_fire) begin
      granted       <= res_granted;
      granted_vc    <= res_gvc;
      vnet_has_idle <= vnet_ok && has_idle;
      vc_idle       <= vc_ok && !cur.active;
      vc_has_credit <= vc_ok && (cur.credits != '0);
      vc_credits    <= vc_ok ? cr_new : '0;
      error_code    <= res_err;
    end
  end

endmodule

// File: sv/ovca_checker.sv
// ----------------------------------------------------------------------------
// ovca_checker
// Port-level checks of the output VC credit allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ovca_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          granted,
  input logic [ovca_pkg::VC_W-1:0]     granted_vc,
  input logic [ovca_pkg::CREDIT_W-1:0] vc_credits,
  input logic [ovca_pkg::ERR_W-1:0]    error_code
);

  // A grant never comes with a credit error.
  a_grant_no_err : assert property (@(posedge clk) disable iff (rst)
    out_valid && granted |-> error_code == ovca_pkg::ERR_OK)
    else $error("grant reported together with a credit error");

  // Without a grant the granted VC field is zero.
  a_no_grant_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !granted |-> granted_vc == '0)
    else $error("granted_vc nonzero without a grant");

  // A counter never exceeds the largest depth.
  a_credit_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> vc_credits <= ovca_pkg::DEPTH_MAX)
    else $error("credit count above maximum depth");

  // One request in flight: after a request transfer the input is closed.
  a_one_in_flight : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // A stalled result holds its value.
  a_result_holds : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(granted_vc) && $stable(vc_credits))
    else $error("result changed while stalled");

endmodule

bind output_vc_credit_allocator ovca_checker u_ovca_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .granted    (granted),
  .granted_vc (granted_vc),
  .vc_credits (vc_credits),
  .error_code (error_code)
);
